FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros for the color ramp block.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, checked out of reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: design/cri_pkg.sv
// ----------------------------------------------------------------------------
// cri_pkg
// Shared widths, codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package cri_pkg;

  localparam int POS_W      = 16;
  localparam int COLOR_W    = 8;
  localparam int RGB_W      = 24;
  localparam int SLOT_W     = 4;
  localparam int INDEX_W    = 8;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam int LANES      = 3;
  localparam int MIN_STOPS  = 2;
  localparam int DIV_STEPS  = 8;
  localparam int STEP_W     = 3;

  localparam logic [STEP_W-1:0]  DIV_LAST = STEP_W'(DIV_STEPS - 1);
  localparam logic [COLOR_W-1:0] CHAN_MAX = 8'd255;

  // Item operation codes
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_EVAL  = 1'b1;

  // Register index (paddr bit 2)
  localparam logic REG_STOP_COUNT = 1'b0;

  typedef struct packed {
    logic wr_stop;
    logic start;
    logic adv;
    logic rd_lo;
    logic cap_b;
    logic cap_a;
    logic norm;
    logic mul0;
    logic mul1;
    logic prep;
    logic div_step;
    logic emit;
  } cmd_t;

  typedef struct packed {
    logic search_more;
  } sts_t;

endpackage

FILE: design/cri_ctrl.sv
// ----------------------------------------------------------------------------
// cri_ctrl
// Sequencer: stop search, segment fetch, multiply, divide and result beat.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cri_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic          in_operation,
  output logic          in_ready,
  input  logic          out_ready,
  output logic          out_valid,
  input  cri_pkg::sts_t sts,
  output cri_pkg::cmd_t cmd
);

  typedef enum logic [10:0] {
    S_IDLE     = 11'b000_0000_0001,
    S_SRCH_RD  = 11'b000_0000_0010,
    S_SRCH_CMP = 11'b000_0000_0100,
    S_FETCH    = 11'b000_0000_1000,
    S_LOAD     = 11'b000_0001_0000,
    S_NORM     = 11'b000_0010_0000,
    S_MUL0     = 11'b000_0100_0000,
    S_MUL1     = 11'b000_1000_0000,
    S_PREP     = 11'b001_0000_0000,
    S_DIV      = 11'b010_0000_0000,
    S_EMIT     = 11'b100_0000_0000
  } state_t;

  state_t                       state_r, state_nxt;
  logic [cri_pkg::STEP_W-1:0]   step_r, step_nxt;
  logic                         out_valid_r, out_valid_nxt;
  logic                         out_free;

  assign in_ready  = (state_r == S_IDLE);
  assign out_valid = out_valid_r;
  assign out_free  = !out_valid_r || out_ready;

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    cmd       = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          if (in_operation == cri_pkg::OP_WRITE) begin
            cmd.wr_stop = 1'b1;
          end else begin
            cmd.start = 1'b1;
            state_nxt = S_SRCH_RD;
          end
        end
      end
      S_SRCH_RD: state_nxt = S_SRCH_CMP;
      S_SRCH_CMP: begin
        if (sts.search_more) begin
          cmd.adv   = 1'b1;
          state_nxt = S_SRCH_RD;
        end else begin
          cmd.cap_b = 1'b1;
          state_nxt = S_FETCH;
        end
      end
      S_FETCH: begin
        cmd.rd_lo = 1'b1;
        state_nxt = S_LOAD;
      end
      S_LOAD: begin
        cmd.cap_a = 1'b1;
        state_nxt = S_NORM;
      end
      S_NORM: begin
        cmd.norm  = 1'b1;
        state_nxt = S_MUL0;
      end
      S_MUL0: begin
        cmd.mul0  = 1'b1;
        state_nxt = S_MUL1;
      end
      S_MUL1: begin
        cmd.mul1  = 1'b1;
        state_nxt = S_PREP;
      end
      S_PREP: begin
        cmd.prep  = 1'b1;
        step_nxt  = cri_pkg::DIV_LAST;
        state_nxt = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        if (step_r == '0) begin
          state_nxt = S_EMIT;
        end else begin
          step_nxt = step_r - 1'b1;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_comb begin
    if (cmd.emit) begin
      out_valid_nxt = 1'b1;
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  `ASSERT_IMPLIES(a_emit_has_room, clk, rst_n, cmd.emit, !out_valid_r || out_ready)
  `ASSERT_NEXT(a_prep_loads_div, clk, rst_n, state_r == S_PREP, (state_r == S_DIV) && (step_r == cri_pkg::DIV_LAST))
  `ASSERT_NEXT(a_eval_starts_search, clk, rst_n, in_valid && in_ready && (in_operation == cri_pkg::OP_EVAL), state_r == S_SRCH_RD)

endmodule

FILE: design/cri_datapath.sv
// ----------------------------------------------------------------------------
// cri_datapath
// Stop memory, segment registers and three color lanes, each with one
// multiplier and a restoring divider that retires one quotient bit a cycle.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module cri_datapath #(
  parameter int MAX_STOPS = 16
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  cri_pkg::cmd_t                       cmd,
  output cri_pkg::sts_t                       sts,
  input  logic [$clog2(MAX_STOPS+1)-1:0]      stop_count,
  input  logic [cri_pkg::SLOT_W-1:0]          in_stop_slot,
  input  logic [cri_pkg::POS_W-1:0]           in_stop_position,
  input  logic [cri_pkg::COLOR_W-1:0]         in_stop_red,
  input  logic [cri_pkg::COLOR_W-1:0]         in_stop_green,
  input  logic [cri_pkg::COLOR_W-1:0]         in_stop_blue,
  input  logic [cri_pkg::INDEX_W-1:0]         in_sample_index,
  output logic [cri_pkg::INDEX_W-1:0]         out_result_index,
  output logic [cri_pkg::COLOR_W-1:0]         out_red,
  output logic [cri_pkg::COLOR_W-1:0]         out_green,
  output logic [cri_pkg::COLOR_W-1:0]         out_blue
);

  localparam int AddrW = $clog2(MAX_STOPS);
  localparam int CntW  = $clog2(MAX_STOPS + 1);
  localparam int LANES = cri_pkg::LANES;

  // Stop memory
  logic [cri_pkg::POS_W-1:0] pos_mem [MAX_STOPS];
  logic [cri_pkg::RGB_W-1:0] col_mem [MAX_STOPS];
  logic [cri_pkg::POS_W-1:0] rd_pos_r;
  logic [cri_pkg::RGB_W-1:0] rd_col_r;

  logic [AddrW+cri_pkg::SLOT_W-1:0] slot_wide;
  logic [AddrW-1:0]                 wr_addr, rd_addr;
  logic                             slot_ok;

  // Segment state
  logic [cri_pkg::INDEX_W-1:0] idx_r;
  logic [cri_pkg::POS_W-1:0]   p_r;
  logic [AddrW-1:0]            j_r;
  logic [cri_pkg::POS_W-1:0]   pos_a_r, pos_b_r;
  logic [cri_pkg::RGB_W-1:0]   col_a_r, col_b_r;
  logic signed [16:0]          d_r, dd_r, d_raw, dd_raw;
  logic                        dd_zero_r;
  logic [24:0]                 div_r;
  logic signed [27:0]          lim;

  // Lanes: 0 red, 1 green, 2 blue
  logic [cri_pkg::COLOR_W-1:0] c0 [LANES];
  logic [cri_pkg::COLOR_W-1:0] c1 [LANES];
  logic signed [8:0]           mul_a [LANES];
  logic signed [16:0]          mul_b [LANES];
  logic signed [25:0]          prod [LANES];
  logic signed [26:0]          acc_r [LANES];
  logic signed [27:0]          n_val [LANES];
  logic [24:0]                 rem_r [LANES];
  logic [cri_pkg::COLOR_W-1:0] quo_r [LANES];
  logic                        neg_r [LANES];
  logic                        big_r [LANES];
  logic [cri_pkg::COLOR_W-1:0] res [LANES];

  logic [cri_pkg::INDEX_W-1:0] out_idx_r;
  logic [cri_pkg::COLOR_W-1:0] out_col_r [LANES];

  assign slot_wide = (AddrW + cri_pkg::SLOT_W)'(in_stop_slot);
  assign wr_addr   = slot_wide[AddrW-1:0];
  assign slot_ok   = (32'(in_stop_slot) < MAX_STOPS);
  assign rd_addr   = cmd.rd_lo ? j_r : j_r + AddrW'(1);

  always_ff @(posedge clk) begin
    if (cmd.wr_stop && slot_ok) begin
      pos_mem[wr_addr] <= in_stop_position;
      col_mem[wr_addr] <= {in_stop_red, in_stop_green, in_stop_blue};
    end
    rd_pos_r <= pos_mem[rd_addr];
    rd_col_r <= col_mem[rd_addr];
  end

  // Step on while another segment remains and the position lies past its end
  assign sts.search_more =
    (((CntW + 1)'(j_r) + (CntW + 1)'(2)) < (CntW + 1)'(stop_count)) && (p_r > rd_pos_r);

  assign dd_raw = $signed({1'b0, pos_b_r}) - $signed({1'b0, pos_a_r});
  assign d_raw  = $signed({1'b0, p_r}) - $signed({1'b0, pos_a_r});
  // Saturation bound 2*dd*256
  assign lim    = $signed({3'b000, dd_r[15:0], 9'b0_0000_0000});

  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      c0[l]    = col_a_r[cri_pkg::COLOR_W*(LANES-1-l) +: cri_pkg::COLOR_W];
      c1[l]    = col_b_r[cri_pkg::COLOR_W*(LANES-1-l) +: cri_pkg::COLOR_W];
      mul_a[l] = cmd.mul1 ? ($signed({1'b0, c1[l]}) - $signed({1'b0, c0[l]}))
                          : $signed({1'b0, c0[l]});
      mul_b[l] = cmd.mul1 ? d_r : dd_r;
      prod[l]  = mul_a[l] * mul_b[l];
      n_val[l] = (28'(acc_r[l]) <<< 1) + 28'(dd_r);
      priority if (dd_zero_r) begin
        res[l] = c1[l];
      end else if (neg_r[l]) begin
        res[l] = '0;
      end else if (big_r[l]) begin
        res[l] = cri_pkg::CHAN_MAX;
      end else begin
        res[l] = quo_r[l];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      j_r <= '0;
    end else if (cmd.start) begin
      j_r <= '0;
    end else if (cmd.adv) begin
      j_r <= j_r + AddrW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= in_sample_index;
      // index*257 is the byte repeated in both halves
      p_r   <= {in_sample_index, in_sample_index};
    end
    if (cmd.cap_b) begin
      pos_b_r <= rd_pos_r;
      col_b_r <= rd_col_r;
    end
    if (cmd.cap_a) begin
      pos_a_r <= rd_pos_r;
      col_a_r <= rd_col_r;
    end
    if (cmd.norm) begin
      dd_zero_r <= (dd_raw == '0);
      // Flip both offsets for a descending segment so the divisor is positive
      if (dd_raw[16]) begin
        dd_r <= -dd_raw;
        d_r  <= -d_raw;
      end else begin
        dd_r <= dd_raw;
        d_r  <= d_raw;
      end
    end
    if (cmd.prep) begin
      div_r <= {1'b0, dd_r[15:0], 8'h00};
    end else if (cmd.div_step) begin
      div_r <= div_r >> 1;
    end
    for (int l = 0; l < LANES; l++) begin
      if (cmd.mul0) begin
        acc_r[l] <= 27'(prod[l]);
      end else if (cmd.mul1) begin
        acc_r[l] <= acc_r[l] + 27'(prod[l]);
      end
      if (cmd.prep) begin
        neg_r[l] <= n_val[l][27];
        big_r[l] <= (n_val[l] >= lim);
        rem_r[l] <= n_val[l][24:0];
        quo_r[l] <= '0;
      end else if (cmd.div_step) begin
        if (rem_r[l] >= div_r) begin
          rem_r[l] <= rem_r[l] - div_r;
          quo_r[l] <= {quo_r[l][cri_pkg::COLOR_W-2:0], 1'b1};
        end else begin
          quo_r[l] <= {quo_r[l][cri_pkg::COLOR_W-2:0], 1'b0};
        end
      end
    end
    if (cmd.emit) begin
      out_idx_r <= idx_r;
      for (int l = 0; l < LANES; l++) begin
        out_col_r[l] <= res[l];
      end
    end
  end

  assign out_result_index = out_idx_r;
  assign out_red          = out_col_r[0];
  assign out_green        = out_col_r[1];
  assign out_blue         = out_col_r[2];

  `ASSERT_NEXT(a_seg_in_range, clk, rst_n, cmd.adv, ((CntW + 1)'(j_r) + (CntW + 1)'(1)) < (CntW + 1)'(stop_count))
  `ASSERT_NEXT(a_divisor_positive, clk, rst_n, cmd.norm, !dd_r[16])

endmodule

FILE: design/color_ramp_interpolator.sv
// ----------------------------------------------------------------------------
// color_ramp_interpolator
// A write beat is taken while the sequencer is idle. An evaluate beat is
//   searched segment by segment, so its time grows with the chosen segment
//   j (0 up to stop_count-2); the next beat is taken once its result is emitted.
// Throughput is set by the stop search (a read and a compare per stop through
//   the single read port) and the restoring divide run by all lanes in step.
// Reset (rst_n, synchronous): stop_count back to 2, control idle, table kept.
// ----------------------------------------------------------------------------
module color_ramp_interpolator #(
  parameter int MAX_STOPS = 16
) (
  input  logic                              clk,
  input  logic                              rst_n,
  // Configuration (APB-style)
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [cri_pkg::CFG_ADDR_W-1:0]    paddr,
  input  logic [cri_pkg::CFG_DATA_W-1:0]    pwdata,
  output logic [cri_pkg::CFG_DATA_W-1:0]    prdata,
  output logic                              pready,
  // Input channel
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic                              in_operation,
  input  logic [cri_pkg::SLOT_W-1:0]        in_stop_slot,
  input  logic [cri_pkg::POS_W-1:0]         in_stop_position,
  input  logic [cri_pkg::COLOR_W-1:0]       in_stop_red,
  input  logic [cri_pkg::COLOR_W-1:0]       in_stop_green,
  input  logic [cri_pkg::COLOR_W-1:0]       in_stop_blue,
  input  logic [cri_pkg::INDEX_W-1:0]       in_sample_index,
  // Result channel
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic [cri_pkg::INDEX_W-1:0]       out_result_index,
  output logic [cri_pkg::COLOR_W-1:0]       out_red,
  output logic [cri_pkg::COLOR_W-1:0]       out_green,
  output logic [cri_pkg::COLOR_W-1:0]       out_blue
);

  localparam int CntW = $clog2(MAX_STOPS + 1);

  logic [CntW-1:0] stop_count_r, stop_count_nxt;
  logic [4:0]      wr_count;
  logic            cfg_wr;
  logic            reg_hit;

  cri_pkg::cmd_t   cmd;
  cri_pkg::sts_t   sts;

  // Register decode: paddr bit 2 selects the register; only stop_count exists
  assign pready  = 1'b1;
  assign reg_hit = (paddr[2] == cri_pkg::REG_STOP_COUNT);
  assign cfg_wr  = psel && penable && pwrite && pready && reg_hit;
  assign prdata  = reg_hit ? cri_pkg::CFG_DATA_W'(stop_count_r) : '0;

  // Saturate the written count to the legal 2..MAX_STOPS range
  assign wr_count = pwdata[4:0];

  always_comb begin
    priority if (32'(wr_count) < cri_pkg::MIN_STOPS) begin
      stop_count_nxt = CntW'(cri_pkg::MIN_STOPS);
    end else if (32'(wr_count) > MAX_STOPS) begin
      stop_count_nxt = CntW'(MAX_STOPS);
    end else begin
      stop_count_nxt = CntW'(wr_count);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stop_count_r <= CntW'(cri_pkg::MIN_STOPS);
    end else if (cfg_wr) begin
      stop_count_r <= stop_count_nxt;
    end
  end

  // Sequencer: owns the handshakes and walks each evaluate beat through
  // search, fetch, multiply, divide and the output register
  cri_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_operation (in_operation),
    .in_ready     (in_ready),
    .out_ready    (out_ready),
    .out_valid    (out_valid),
    .sts          (sts),
    .cmd          (cmd)
  );

  // Datapath: stop table, segment registers, three color lanes and the
  // output payload register that holds a finished beat while out_ready is low
  cri_datapath #(
    .MAX_STOPS (MAX_STOPS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .stop_count       (stop_count_r),
    .in_stop_slot     (in_stop_slot),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_sample_index  (in_sample_index),
    .out_result_index (out_result_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

endmodule

FILE: dv/color_ramp_interpolator_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// color_ramp_interpolator_tb
// Checks the gradient block beat by beat against a built-in fixed-point
// model of the stop table, the segment search and the rounded, clamped
// per-channel interpolation, under random idling on both channels.
// ----------------------------------------------------------------------------
module color_ramp_interpolator_tb;

  localparam int RAMP_SLOTS     = 16;
  localparam int SETTLE_CYCLES  = 64;    // longest evaluate searches to segment 14
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 5000;  // cycles with no handshake at all
  localparam logic [cri_pkg::CFG_ADDR_W-1:0] STOP_COUNT_ADDR =
    {cri_pkg::REG_STOP_COUNT, 2'b00};

  typedef struct packed {
    logic [cri_pkg::INDEX_W-1:0] idx;
    logic [cri_pkg::COLOR_W-1:0] red;
    logic [cri_pkg::COLOR_W-1:0] green;
    logic [cri_pkg::COLOR_W-1:0] blue;
  } ramp_color_t;

  // Drive every input to a known value from time zero.
  logic                           clk              = 1'b0;
  logic                           rst_n            = 1'b0;
  logic                           psel             = 1'b0;
  logic                           penable          = 1'b0;
  logic                           pwrite           = 1'b0;
  logic [cri_pkg::CFG_ADDR_W-1:0] paddr            = '0;
  logic [cri_pkg::CFG_DATA_W-1:0] pwdata           = '0;
  logic [cri_pkg::CFG_DATA_W-1:0] prdata;
  logic                           pready;
  logic                           in_valid         = 1'b0;
  logic                           in_ready;
  logic                           in_operation     = cri_pkg::OP_WRITE;
  logic [cri_pkg::SLOT_W-1:0]     in_stop_slot     = '0;
  logic [cri_pkg::POS_W-1:0]      in_stop_position = '0;
  logic [cri_pkg::COLOR_W-1:0]    in_stop_red      = '0;
  logic [cri_pkg::COLOR_W-1:0]    in_stop_green    = '0;
  logic [cri_pkg::COLOR_W-1:0]    in_stop_blue     = '0;
  logic [cri_pkg::INDEX_W-1:0]    in_sample_index  = '0;
  logic                           out_valid;
  logic                           out_ready        = 1'b0;
  logic [cri_pkg::INDEX_W-1:0]    out_result_index;
  logic [cri_pkg::COLOR_W-1:0]    out_red;
  logic [cri_pkg::COLOR_W-1:0]    out_green;
  logic [cri_pkg::COLOR_W-1:0]    out_blue;

  // Shadow copy of the block's state and register.
  logic [cri_pkg::POS_W-1:0] stop_pos_q [RAMP_SLOTS];
  logic [cri_pkg::RGB_W-1:0] stop_rgb_q [RAMP_SLOTS];
  int                        stop_cnt_q = cri_pkg::MIN_STOPS;

  ramp_color_t expected_colors [$];
  ramp_color_t want_color;

  int   in_idle_pct   = 0;     // chance per cycle that the sender holds off
  int   out_idle_pct  = 0;     // chance per cycle that the receiver holds off
  int   hold_left     = 0;     // remaining cycles of a forced receiver hold-off
  logic hold_toggle   = 1'b0;  // flipped by a test to request a hold-off
  logic hold_seen     = 1'b0;  // last request the receiver has taken up
  int   items_sent    = 0;
  int   err_cnt       = 0;
  int   stall_cycles  = 0;

  color_ramp_interpolator #(
    .MAX_STOPS(RAMP_SLOTS)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .psel             (psel),
    .penable          (penable),
    .pwrite           (pwrite),
    .paddr            (paddr),
    .pwdata           (pwdata),
    .prdata           (prdata),
    .pready           (pready),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_operation     (in_operation),
    .in_stop_slot     (in_stop_slot),
    .in_stop_position (in_stop_position),
    .in_stop_red      (in_stop_red),
    .in_stop_green    (in_stop_green),
    .in_stop_blue     (in_stop_blue),
    .in_sample_index  (in_sample_index),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_result_index (out_result_index),
    .out_red          (out_red),
    .out_green        (out_green),
    .out_blue         (out_blue)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // --------------------------------------------------------------------------
  // Color model
  // --------------------------------------------------------------------------

  // Interpolate one channel: exact c0 + d*(c1-c0)/dd, halves rounded up,
  // then clamp to the 8-bit range. A zero-length segment takes the later stop.
  function automatic logic [cri_pkg::COLOR_W-1:0] lerp_channel8(
      input logic [cri_pkg::COLOR_W-1:0] c0,
      input logic [cri_pkg::COLOR_W-1:0] c1,
      input longint d,
      input longint dd);
    longint a, b, num, den, q;
    if (dd == 0) return c1;
    a = longint'(c0);
    b = longint'(c1);
    // Flip a descending segment so the divisor stays positive.
    if (dd < 0) begin
      dd = -dd;
      d  = -d;
    end
    num = 2 * (a * dd + d * (b - a)) + dd;
    den = 2 * dd;
    // Floor division; plain / truncates toward zero.
    q = (num >= 0) ? num / den : -((-num + den - 1) / den);
    if (q < 0) q = 0;
    if (q > 255) q = 255;
    return cri_pkg::COLOR_W'(q);
  endfunction

  function automatic ramp_color_t predict_color(input logic [cri_pkg::INDEX_W-1:0] index);
    longint      p, d, dd;
    int          j;
    ramp_color_t res;
    // 256-entry table: position is exactly index*257.
    p = longint'(index) * 257;
    // Advance through the segments while the position lies past the upper stop;
    // the last segment in use also covers everything beyond it.
    j = 0;
    while (j + 2 < stop_cnt_q && p > longint'(stop_pos_q[j+1])) j++;
    d  = p - longint'(stop_pos_q[j]);
    dd = longint'(stop_pos_q[j+1]) - longint'(stop_pos_q[j]);
    res.idx   = index;
    res.red   = lerp_channel8(stop_rgb_q[j][23:16], stop_rgb_q[j+1][23:16], d, dd);
    res.green = lerp_channel8(stop_rgb_q[j][15:8],  stop_rgb_q[j+1][15:8],  d, dd);
    res.blue  = lerp_channel8(stop_rgb_q[j][7:0],   stop_rgb_q[j+1][7:0],   d, dd);
    return res;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] want,
                                      input logic [31:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      err_cnt++;
    end
  endfunction

  // --------------------------------------------------------------------------
  // Input beats
  // --------------------------------------------------------------------------

  // Offer one beat and return at the edge that accepts it. Valid is left high:
  // the next call either drops it for a gap or presents the next beat in the
  // same step, and settle_ramp drops it before any quiet stretch.
  task automatic send_beat(input logic op, input logic [cri_pkg::SLOT_W-1:0] slot,
                           input logic [cri_pkg::POS_W-1:0] pos,
                           input logic [cri_pkg::RGB_W-1:0] rgb,
                           input logic [cri_pkg::INDEX_W-1:0] index);
    if ($urandom_range(99) < in_idle_pct) begin
      in_valid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < in_idle_pct);
    end
    in_valid         <= 1'b1;
    in_operation     <= op;
    in_stop_slot     <= slot;
    in_stop_position <= pos;
    in_stop_red      <= rgb[23:16];
    in_stop_green    <= rgb[15:8];
    in_stop_blue     <= rgb[7:0];
    in_sample_index  <= index;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    // Beat taken at this edge: update the shadow table or queue the color.
    items_sent++;
    if (op == cri_pkg::OP_WRITE) begin
      stop_pos_q[slot] = pos;
      stop_rgb_q[slot] = rgb;
    end else begin
      expected_colors.insert(expected_colors.size(), predict_color(index));
    end
  endtask

  // Unused fields carry noise so every input bit toggles.
  task automatic write_stop(input logic [cri_pkg::SLOT_W-1:0] slot,
                            input logic [cri_pkg::POS_W-1:0] pos,
                            input logic [cri_pkg::RGB_W-1:0] rgb);
    send_beat(cri_pkg::OP_WRITE, slot, pos, rgb, cri_pkg::INDEX_W'($urandom));
  endtask

  task automatic eval_sample(input logic [cri_pkg::INDEX_W-1:0] index);
    send_beat(cri_pkg::OP_EVAL, cri_pkg::SLOT_W'($urandom), cri_pkg::POS_W'($urandom),
              cri_pkg::RGB_W'($urandom), index);
  endtask

  // Mostly uniform; otherwise an end of the table or an index straddling a stop.
  function automatic logic [cri_pkg::INDEX_W-1:0] pick_index();
    int k, v;
    if ($urandom_range(9) == 0) return $urandom_range(1) ? 8'd255 : 8'd0;
    if ($urandom_range(3) != 0) return cri_pkg::INDEX_W'($urandom);
    k = $urandom_range(stop_cnt_q - 1);
    v = int'(stop_pos_q[k]) / 257 + $urandom_range(1);
    return (v > 255) ? 8'd255 : cri_pkg::INDEX_W'(v);
  endfunction

  // Drop valid, wait out every pending color, then let the block go quiet.
  task automatic settle_ramp();
    in_valid <= 1'b0;
    while (expected_colors.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // Write stop_count (setup + access), then read it back. Upper bits of the
  // write data are noise; only the low five bits land in the register.
  task automatic write_stop_count(input logic [4:0] count_word);
    logic [cri_pkg::CFG_DATA_W-1:0] wdata;
    wdata = {27'($urandom), count_word};
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= STOP_COUNT_ADDR;
    pwdata  <= wdata;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    // Saturate into 2..16 as the register does.
    if (count_word < cri_pkg::MIN_STOPS) stop_cnt_q = cri_pkg::MIN_STOPS;
    else if (count_word > RAMP_SLOTS)    stop_cnt_q = RAMP_SLOTS;
    else                                 stop_cnt_q = count_word;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    check_field("stop_count", stop_cnt_q, prdata);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // --------------------------------------------------------------------------
  // Tests
  // --------------------------------------------------------------------------

  // Fill every slot with an evenly spaced, sorted ramp, then probe both ends
  // with two stops and with all sixteen in use.
  task automatic test_table_fill();
    for (int k = 0; k < RAMP_SLOTS; k++) begin
      write_stop(cri_pkg::SLOT_W'(k), cri_pkg::POS_W'(k * 4369),
                 {8'(k * 17), 8'(255 - k * 17), (k % 2 != 0) ? 8'd255 : 8'd0});
    end
    // Two stops: the far end extrapolates off the first segment and clamps.
    eval_sample(8'd0);
    eval_sample(8'd255);
    settle_ramp();
    write_stop_count(5'd16);
    eval_sample(8'd0);
    eval_sample(8'd255);
  endtask

  // Two stops at one position: every index takes the later stop's color.
  task automatic test_coincident_stops();
    settle_ramp();
    write_stop_count(5'd1);  // saturates to two stops
    write_stop(4'd0, 16'h4000, {8'd10, 8'd200, 8'd30});
    write_stop(4'd1, 16'h4000, {8'd240, 8'd20, 8'd128});
    eval_sample(8'd64);
  endtask

  // Second stop below the first: descending segment, results clamp.
  task automatic test_unsorted_stops();
    write_stop(4'd1, 16'h1000, {8'd255, 8'd0, 8'd255});
    eval_sample(8'd0);
    eval_sample(8'd255);
  endtask

  // Random gradients at one stop_count setting: mostly fresh sorted tables
  // followed by a burst of lookups, mixed with stray writes to any slot that
  // may leave the table unsorted, and lookup-only bursts.
  task automatic test_random_gradients(input logic [4:0] count_word, input int n_items);
    int first, kind, n_eval, lo, hi, p, step;
    first = items_sent;
    settle_ramp();
    write_stop_count(count_word);
    while (items_sent - first < n_items) begin
      kind = $urandom_range(99);
      if (kind < 60) begin
        // Sorted stops between lo and hi; a zero step makes coincident stops.
        lo = $urandom_range(1) ? 0 : $urandom_range(20000);
        hi = $urandom_range(1) ? 65535 : $urandom_range(65535, lo);
        p  = lo;
        for (int k = 0; k < stop_cnt_q; k++) begin
          if (k > 0) begin
            step = ($urandom_range(7) == 0) ? 0
                   : $urandom_range(2 * (hi - p) / (stop_cnt_q - k));
            p = (p + step > hi) ? hi : p + step;
          end
          write_stop(cri_pkg::SLOT_W'(k), cri_pkg::POS_W'(p), cri_pkg::RGB_W'($urandom));
        end
        n_eval = $urandom_range(12, 4);
      end else if (kind < 80) begin
        write_stop(cri_pkg::SLOT_W'($urandom), cri_pkg::POS_W'($urandom),
                   cri_pkg::RGB_W'($urandom));
        n_eval = $urandom_range(3);
      end else begin
        n_eval = $urandom_range(6, 1);
      end
      repeat (n_eval) eval_sample(pick_index());
    end
  endtask

  // Hold the result channel off for a long stretch while lookups keep coming,
  // so the block fills and stalls its input.
  task automatic test_backpressure();
    hold_toggle = ~hold_toggle;
    repeat (30) eval_sample(pick_index());
  endtask

  // --------------------------------------------------------------------------
  // Receiver and result check
  // --------------------------------------------------------------------------

  // Take up a hold-off request and count it down here at every edge.
  always @(posedge clk) begin
    if (hold_seen != hold_toggle) begin
      hold_seen <= hold_toggle;
      hold_left <= HOLD_CYCLES - 1;
      out_ready <= 1'b0;
    end else if (hold_left > 0) begin
      out_ready <= 1'b0;
      hold_left <= hold_left - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= out_idle_pct);
    end
  end

  // Compare every accepted result beat with the oldest pending color.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (expected_colors.size() == 0) begin
        $error("result beat with no lookup pending: index %0d", out_result_index);
        err_cnt++;
      end else begin
        want_color = expected_colors.pop_front();
        check_field("result_index", want_color.idx,   out_result_index);
        check_field("out_red",      want_color.red,   out_red);
        check_field("out_green",    want_color.green, out_green);
        check_field("out_blue",     want_color.blue,  out_blue);
      end
    end
  end

  // Count cycles with no handshake on any channel; end the run if it hangs.
  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
        stall_cycles = 0;
      else
        stall_cycles++;
    end
    $error("watchdog: no handshake for %0d cycles", WATCHDOG_LIMIT);
    $display("*** FAILED ***");
    $finish;
  end

  // --------------------------------------------------------------------------
  // Sequence
  // --------------------------------------------------------------------------

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    // Sender idles lightly, receiver heavily.
    in_idle_pct  = 36;
    out_idle_pct = 77;
    test_table_fill();
    test_coincident_stops();
    test_unsorted_stops();
    test_random_gradients(5'd5, 110);
    test_random_gradients(5'd31, 100);

    // Swap the idling.
    in_idle_pct  = 77;
    out_idle_pct = 36;
    test_random_gradients(5'd0, 100);
    test_random_gradients(5'd17, 100);

    // No idling, a long hold-off, then a full table.
    in_idle_pct  = 0;
    out_idle_pct = 0;
    test_random_gradients(5'($urandom_range(15, 3)), 100);
    test_backpressure();
    test_random_gradients(5'd16, 110);

    settle_ramp();
    if (err_cnt == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
